FILE: design/rfles_pkg.sv
package rfles_pkg;

    // Depth of the deferred user-event queue (1 to 64)
    localparam int DeferDepth = 8;
    localparam int PTR_W = (DeferDepth > 1) ? $clog2(DeferDepth) : 1;
    localparam int CNT_W = $clog2(DeferDepth + 1);
    localparam int SUM_W = $clog2(2 * DeferDepth);

    // Link states
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_INIT      = 3'd1,
        ST_RF_IDLE   = 3'd2,
        ST_DISCOVERY = 3'd3,
        ST_DISCOVERED = 3'd4,
        ST_DATA_XCHG = 3'd5,
        ST_RECOVERY  = 3'd6,
        ST_SHUTDOWN  = 3'd7
    } link_state_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_OK            = 3'd0,
        STS_PENDING       = 3'd1,
        STS_INVALID_STATE = 3'd2,
        STS_INVALID_EVENT = 3'd3,
        STS_DEFERRED      = 3'd4,
        STS_QUEUE_FULL    = 3'd5
    } status_t;

    // Event codes with a meaning of their own
    localparam logic [3:0] EV_INVALID = 4'd15;

    // Table entry codes beyond the eight states
    localparam logic [3:0] TGT_NONE     = 4'd8;
    localparam logic [3:0] TGT_CONN_DISC = 4'd9;
    localparam logic [3:0] TGT_CONN_DEV  = 4'd10;

    // Outstanding user event marker
    localparam logic [3:0] USER_EV_NONE = 4'd8;

    // Pending handler result
    localparam logic [1:0] HRES_PENDING = 2'd1;

    // User-event table: row is current state, column is event
    localparam logic [3:0] USER_MAP [8][8] = '{
        '{4'd1, 4'd8, 4'd8, 4'd8, 4'd8,  4'd8,  4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8,  4'd8,  4'd8, 4'd8},
        '{4'd8, 4'd7, 4'd9, 4'd2, 4'd8,  4'd8,  4'd2, 4'd8},
        '{4'd8, 4'd7, 4'd9, 4'd2, 4'd8,  4'd8,  4'd3, 4'd8},
        '{4'd8, 4'd7, 4'd9, 4'd2, 4'd10, 4'd8,  4'd4, 4'd8},
        '{4'd8, 4'd7, 4'd9, 4'd2, 4'd8,  4'd10, 4'd5, 4'd5},
        '{4'd8, 4'd7, 4'd8, 4'd8, 4'd8,  4'd8,  4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8,  4'd8,  4'd8, 4'd8}
    };

    // Internal-event table: row is current state, column is event minus 8
    // (the last column is never selected by a valid internal event)
    localparam logic [3:0] INT_MAP [8][8] = '{
        '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd2, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7, 4'd8},
        '{4'd2, 4'd6, 4'd6, 4'd8, 4'd8, 4'd8, 4'd2, 4'd8},
        '{4'd3, 4'd6, 4'd6, 4'd4, 4'd8, 4'd8, 4'd3, 4'd8},
        '{4'd4, 4'd6, 4'd6, 4'd8, 4'd5, 4'd9, 4'd9, 4'd8},
        '{4'd5, 4'd6, 4'd6, 4'd8, 4'd8, 4'd9, 4'd5, 4'd8},
        '{4'd9, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd8},
        '{4'd0, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd8}
    };

    // Connector table per state: disc true, disc false, dev true, dev false
    localparam logic [3:0] CONN_MAP [8][4] = '{
        '{4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd3, 4'd2, 4'd8, 4'd8},
        '{4'd3, 4'd2, 4'd8, 4'd8},
        '{4'd3, 4'd2, 4'd5, 4'd8},
        '{4'd3, 4'd2, 4'd4, 4'd8},
        '{4'd3, 4'd2, 4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8}
    };

    // Transition handler per current state and target state
    localparam logic [3:0] HANDLER_MAP [8][8] = '{
        '{4'd0, 4'd1, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd2},
        '{4'd0, 4'd0, 4'd3, 4'd4,  4'd0,  4'd0,  4'd5, 4'd2},
        '{4'd0, 4'd0, 4'd6, 4'd7,  4'd8,  4'd0,  4'd5, 4'd2},
        '{4'd0, 4'd0, 4'd9, 4'd10, 4'd11, 4'd12, 4'd5, 4'd2},
        '{4'd0, 4'd0, 4'd9, 4'd10, 4'd13, 4'd14, 4'd5, 4'd2},
        '{4'd0, 4'd0, 4'd0, 4'd4,  4'd0,  4'd0,  4'd0, 4'd2},
        '{4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0}
    };

    // Requests from the sequencer to the deferred-event queue
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] push_event;
    } defer_ctl_t;

    // Queue status seen by the sequencer
    typedef struct packed {
        logic full;
        logic not_empty;
    } defer_sts_t;

endpackage

FILE: design/rfles_defer_fifo.sv
module rfles_defer_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  rfles_pkg::defer_ctl_t ctl,
    output rfles_pkg::defer_sts_t sts,
    output logic [2:0]          pop_event
);

    logic [2:0]                   mem [rfles_pkg::DeferDepth];
    logic [rfles_pkg::PTR_W-1:0]  head_reg;
    logic [rfles_pkg::PTR_W-1:0]  head_next;
    logic [rfles_pkg::CNT_W-1:0]  count_reg;
    logic [rfles_pkg::CNT_W-1:0]  count_next;
    logic [rfles_pkg::SUM_W-1:0]  tail_sum;
    logic [rfles_pkg::PTR_W-1:0]  tail;
    logic [2:0]                   rdata_reg;

    // Derive fill status
    assign sts.full      = (count_reg == rfles_pkg::CNT_W'(rfles_pkg::DeferDepth));
    assign sts.not_empty = (count_reg != '0);
    assign pop_event     = rdata_reg;

    // Tail address: head plus count, wrapped once
    always_comb
    begin
        tail_sum = rfles_pkg::SUM_W'(head_reg) + rfles_pkg::SUM_W'(count_reg);
        if (tail_sum >= rfles_pkg::SUM_W'(rfles_pkg::DeferDepth))
        begin
            tail_sum = tail_sum - rfles_pkg::SUM_W'(rfles_pkg::DeferDepth);
        end
        tail = tail_sum[rfles_pkg::PTR_W-1:0];
    end

    // Advance pointers
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
            if (head_reg == rfles_pkg::PTR_W'(rfles_pkg::DeferDepth - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Write at tail; on pop, register the head entry
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail] <= ctl.push_event;
        end
        if (ctl.pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

endmodule

FILE: design/rf_link_event_sequencer_core.sv
// Table-driven NFC link sequencer. One event transfer is accepted per clock
// and its result appears in the output register in the cycle after; a new
// event is taken every cycle as long as the result side is not stalled. User
// events that arrive while a transition is busy go into a deferred queue held
// in a synchronous memory, unless it is full; a later completing event pops
// the queue head and reports it on replay_valid/replay_event for the host to
// post again. The memory read for the pop is registered at the accept edge,
// alongside the result. No clearing pass is needed after reset.
module rf_link_event_sequencer_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] event_code,
    input  logic       disc_mode_check,
    input  logic       device_type_check,
    input  logic [1:0] handler_result,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [2:0] new_state,
    output logic [3:0] handler_called,
    output logic       replay_valid,
    output logic [2:0] replay_event,
    output logic       user_done
);

    rfles_pkg::link_state_t state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic [3:0]             open_user_reg, open_user_next;
    logic                   out_valid_reg;
    rfles_pkg::status_t     status_reg, status_next;
    logic [3:0]             handler_reg, handler_next;
    logic                   rvalid_reg;
    logic                   done_reg, done_next;

    rfles_pkg::defer_ctl_t  dq_ctl;
    rfles_pkg::defer_sts_t  dq_sts;
    logic [2:0]             dq_event;

    logic                   accept;
    logic                   is_user;
    logic [3:0]             entry;
    logic [3:0]             target;
    logic                   finish;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign is_user  = !event_code[3];

    // Look up and resolve the table entry
    always_comb
    begin
        if (is_user)
        begin
            entry = rfles_pkg::USER_MAP[state_reg][event_code[2:0]];
        end
        else
        begin
            entry = rfles_pkg::INT_MAP[state_reg][event_code[2:0]];
        end
        if (entry == rfles_pkg::TGT_CONN_DISC)
        begin
            target = rfles_pkg::CONN_MAP[state_reg][disc_mode_check ? 2'd0 : 2'd1];
        end
        else if (entry == rfles_pkg::TGT_CONN_DEV)
        begin
            target = rfles_pkg::CONN_MAP[state_reg][device_type_check ? 2'd2 : 2'd3];
        end
        else
        begin
            target = entry;
        end
    end

    // Step the sequencer for one event
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        open_user_next = open_user_reg;
        status_next    = rfles_pkg::STS_OK;
        handler_next   = '0;
        done_next      = 1'b0;
        finish         = 1'b0;
        dq_ctl.push       = 1'b0;
        dq_ctl.pop        = 1'b0;
        dq_ctl.push_event = event_code[2:0];

        if (event_code == rfles_pkg::EV_INVALID)
        begin
            status_next = rfles_pkg::STS_INVALID_EVENT;
        end
        else if (is_user && busy_reg)
        begin
            // Defer while a transition is busy
            if (dq_sts.full)
            begin
                status_next = rfles_pkg::STS_QUEUE_FULL;
            end
            else
            begin
                dq_ctl.push = accept;
                status_next = rfles_pkg::STS_DEFERRED;
            end
        end
        else
        begin
            if (is_user)
            begin
                open_user_next = event_code;
            end
            if (target[3])
            begin
                status_next = rfles_pkg::STS_INVALID_STATE;
            end
            else if (is_user || (target[2:0] != state_reg))
            begin
                handler_next = rfles_pkg::HANDLER_MAP[state_reg][target[2:0]];
                if (handler_next != '0)
                begin
                    busy_next   = 1'b1;
                    status_next = (handler_result == rfles_pkg::HRES_PENDING) ?
                                  rfles_pkg::STS_PENDING : rfles_pkg::STS_OK;
                end
                state_next = rfles_pkg::link_state_t'(target[2:0]);
            end
            finish = (status_next != rfles_pkg::STS_PENDING);
        end

        // Completion: replay a deferred event or close the user event
        if (finish)
        begin
            busy_next = 1'b0;
            if (dq_sts.not_empty)
            begin
                dq_ctl.pop = accept;
            end
            else if (open_user_next != rfles_pkg::USER_EV_NONE)
            begin
                open_user_next = rfles_pkg::USER_EV_NONE;
                done_next      = 1'b1;
            end
        end
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfles_pkg::ST_IDLE;
            busy_reg      <= 1'b0;
            open_user_reg <= rfles_pkg::USER_EV_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                busy_reg      <= busy_next;
                open_user_reg <= open_user_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture result payload on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            handler_reg <= handler_next;
            rvalid_reg  <= dq_ctl.pop;
            done_reg    <= done_next;
        end
    end

    rfles_defer_fifo u_defer_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dq_ctl),
        .sts       (dq_sts),
        .pop_event (dq_event)
    );

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign new_state      = state_reg;
    assign handler_called = handler_reg;
    assign replay_valid   = rvalid_reg;
    assign replay_event   = rvalid_reg ? dq_event : 3'd0;
    assign user_done      = done_reg;

endmodule

FILE: bench/tb_rf_link_event_sequencer_core.sv
`timescale 1ns / 100ps

module tb_rf_link_event_sequencer_core;

    // Event codes
    localparam logic [3:0] EV_INIT        = 4'd0;
    localparam logic [3:0] EV_DEINIT      = 4'd1;
    localparam logic [3:0] EV_CFG_DISC    = 4'd2;
    localparam logic [3:0] EV_STOP_DISC   = 4'd3;
    localparam logic [3:0] EV_ACTIVATE    = 4'd4;
    localparam logic [3:0] EV_DEACT_SLEEP = 4'd5;
    localparam logic [3:0] EV_CONFIG      = 4'd6;
    localparam logic [3:0] EV_DATA_XCHG   = 4'd7;
    localparam logic [3:0] EV_REQ_DONE    = 4'd8;
    localparam logic [3:0] EV_TIMEOUT     = 4'd9;
    localparam logic [3:0] EV_RECOVERY    = 4'd10;
    localparam logic [3:0] EV_DISCOVERED  = 4'd11;
    localparam logic [3:0] EV_ACTIVATED   = 4'd12;
    localparam logic [3:0] EV_DEACTIVATED = 4'd13;
    localparam logic [3:0] EV_FAILED      = 4'd14;
    localparam logic [3:0] EV_USER_LIMIT  = 4'd8;

    // Handler results and handler ids
    localparam logic [1:0] HRES_OK    = 2'd0;
    localparam logic [1:0] HRES_FAIL  = 2'd2;
    localparam logic [1:0] HRES_SPARE = 2'd3;
    localparam logic [3:0] HND_NONE   = 4'd0;
    localparam logic [3:0] HND_INIT   = 4'd1;

    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 375;
    localparam int DIRECTED_LEN = 25;

    // Next-state tables: row is current state
    localparam logic [3:0] user_next [8][8] = '{
        '{1, 8, 8, 8, 8,  8,  8, 8},
        '{8, 8, 8, 8, 8,  8,  8, 8},
        '{8, 7, 9, 2, 8,  8,  2, 8},
        '{8, 7, 9, 2, 8,  8,  3, 8},
        '{8, 7, 9, 2, 10, 8,  4, 8},
        '{8, 7, 9, 2, 8,  10, 5, 5},
        '{8, 7, 8, 8, 8,  8,  8, 8},
        '{8, 8, 8, 8, 8,  8,  8, 8}
    };
    localparam logic [3:0] internal_next [8][7] = '{
        '{0, 8, 8, 8, 8, 8, 8},
        '{2, 7, 8, 8, 8, 8, 7},
        '{2, 6, 6, 8, 8, 8, 2},
        '{3, 6, 6, 4, 8, 8, 3},
        '{4, 6, 6, 8, 5, 9, 9},
        '{5, 6, 6, 8, 8, 9, 5},
        '{9, 0, 8, 8, 8, 8, 0},
        '{0, 7, 8, 8, 8, 8, 0}
    };
    // Branches per state: discovery set, clear, device set, clear
    localparam logic [3:0] branch_next [8][4] = '{
        '{8, 8, 8, 8},
        '{8, 8, 8, 8},
        '{3, 2, 8, 8},
        '{3, 2, 8, 8},
        '{3, 2, 5, 8},
        '{3, 2, 4, 8},
        '{3, 2, 8, 8},
        '{8, 8, 8, 8}
    };
    // Handler id per current state and target state
    localparam logic [3:0] handler_id [8][8] = '{
        '{0, 1, 0, 0,  0,  0,  0, 0},
        '{0, 0, 0, 0,  0,  0,  0, 2},
        '{0, 0, 3, 4,  0,  0,  5, 2},
        '{0, 0, 6, 7,  8,  0,  5, 2},
        '{0, 0, 9, 10, 11, 12, 5, 2},
        '{0, 0, 9, 10, 13, 14, 5, 2},
        '{0, 0, 0, 4,  0,  0,  0, 2},
        '{0, 0, 0, 0,  0,  0,  0, 0}
    };

    typedef struct packed {
        logic [3:0] code;
        logic       disc;
        logic       dev;
        logic [1:0] hres;
    } link_event_t;

    typedef struct packed {
        rfles_pkg::status_t     status;
        rfles_pkg::link_state_t new_state;
        logic [3:0]             handler;
        logic                   replay;
        logic [2:0]             replay_ev;
        logic                   done;
    } seq_result_t;

    typedef struct packed {
        link_event_t item;
        logic        typed;
        seq_result_t want;
    } directed_row_t;

    // Directed sequence; rows marked typed carry their result by hand
    localparam directed_row_t directed_plan [DIRECTED_LEN] = '{
        '{'{rfles_pkg::EV_INVALID, 1'b1, 1'b1, HRES_SPARE}, 1'b1,
          '{rfles_pkg::STS_INVALID_EVENT, rfles_pkg::ST_IDLE, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_DEINIT, 1'b0, 1'b0, HRES_OK}, 1'b1,
          '{rfles_pkg::STS_INVALID_STATE, rfles_pkg::ST_IDLE, HND_NONE, 1'b0, 3'd0, 1'b1}},
        '{'{EV_REQ_DONE, 1'b1, 1'b0, HRES_FAIL}, 1'b1,
          '{rfles_pkg::STS_OK, rfles_pkg::ST_IDLE, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_INIT, 1'b0, 1'b1, rfles_pkg::HRES_PENDING}, 1'b1,
          '{rfles_pkg::STS_PENDING, rfles_pkg::ST_INIT, HND_INIT, 1'b0, 3'd0, 1'b0}},
        '{'{EV_INIT, 1'b1, 1'b1, HRES_SPARE}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_DEINIT, 1'b0, 1'b0, HRES_OK}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_CFG_DISC, 1'b1, 1'b0, rfles_pkg::HRES_PENDING}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_STOP_DISC, 1'b0, 1'b1, HRES_FAIL}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_ACTIVATE, 1'b1, 1'b1, HRES_OK}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_DEACT_SLEEP, 1'b0, 1'b0, HRES_SPARE}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_CONFIG, 1'b1, 1'b0, rfles_pkg::HRES_PENDING}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_DATA_XCHG, 1'b0, 1'b1, HRES_OK}, 1'b1,
          '{rfles_pkg::STS_DEFERRED, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_DATA_XCHG, 1'b1, 1'b1, HRES_SPARE}, 1'b1,
          '{rfles_pkg::STS_QUEUE_FULL, rfles_pkg::ST_INIT, HND_NONE, 1'b0, 3'd0, 1'b0}},
        '{'{EV_REQ_DONE, 1'b0, 1'b0, HRES_OK}, 1'b1,
          '{rfles_pkg::STS_OK, rfles_pkg::ST_RF_IDLE, HND_NONE, 1'b1, EV_INIT[2:0], 1'b0}},
        '{'{EV_CFG_DISC, 1'b1, 1'b0, HRES_FAIL}, 1'b0, '0},
        '{'{EV_DISCOVERED, 1'b0, 1'b1, HRES_SPARE}, 1'b0, '0},
        '{'{EV_ACTIVATE, 1'b0, 1'b1, HRES_OK}, 1'b0, '0},
        '{'{EV_DATA_XCHG, 1'b1, 1'b1, rfles_pkg::HRES_PENDING}, 1'b0, '0},
        '{'{EV_DEACTIVATED, 1'b0, 1'b0, HRES_OK}, 1'b0, '0},
        '{'{EV_TIMEOUT, 1'b1, 1'b1, HRES_OK}, 1'b0, '0},
        '{'{EV_RECOVERY, 1'b0, 1'b0, HRES_OK}, 1'b0, '0},
        '{'{EV_FAILED, 1'b1, 1'b0, HRES_OK}, 1'b0, '0},
        '{'{EV_INIT, 1'b0, 1'b0, HRES_OK}, 1'b0, '0},
        '{'{EV_CONFIG, 1'b1, 1'b1, HRES_FAIL}, 1'b0, '0},
        '{'{EV_REQ_DONE, 1'b0, 1'b0, HRES_OK}, 1'b0, '0}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [3:0] event_code;
    logic       disc_mode_check;
    logic       device_type_check;
    logic [1:0] handler_result;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [2:0] new_state;
    logic [3:0] handler_called;
    logic       replay_valid;
    logic [2:0] replay_event;
    logic       user_done;

    // Predicted sequencer state
    rfles_pkg::link_state_t link_state;
    logic                   link_busy;
    logic [3:0]             open_user;
    logic [2:0]             defer_mem [rfles_pkg::DeferDepth];
    int                     defer_head;
    int                     defer_count;

    seq_result_t predicted_results [$];

    int sender_idle_pct;
    int recv_stall_pct;
    bit hold_pending;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int transfers;
    int results_checked;
    int replays_seen;
    int done_seen;
    int full_seen;
    int pending_seen;

    rf_link_event_sequencer_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .event_code        (event_code),
        .disc_mode_check   (disc_mode_check),
        .device_type_check (device_type_check),
        .handler_result    (handler_result),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .new_state         (new_state),
        .handler_called    (handler_called),
        .replay_valid      (replay_valid),
        .replay_event      (replay_event),
        .user_done         (user_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Resolve a table entry through the connector branches
    function automatic logic [3:0] resolve_target(input logic [3:0] entry,
                                                  input logic disc, input logic dev);
        if (entry == rfles_pkg::TGT_CONN_DISC)
            return branch_next[link_state][disc ? 0 : 1];
        if (entry == rfles_pkg::TGT_CONN_DEV)
            return branch_next[link_state][dev ? 2 : 3];
        return entry;
    endfunction

    // Advance the predicted sequencer by one event and form its result
    task automatic sequence_event(input link_event_t ev, output seq_result_t res);
        logic [3:0] target;
        logic       user;
        res = '0;
        res.status = rfles_pkg::STS_OK;
        user = (ev.code < EV_USER_LIMIT);
        if (ev.code == rfles_pkg::EV_INVALID)
        begin
            res.status = rfles_pkg::STS_INVALID_EVENT;
        end
        else if (user && link_busy)
        begin
            if (defer_count >= rfles_pkg::DeferDepth)
            begin
                res.status = rfles_pkg::STS_QUEUE_FULL;
            end
            else
            begin
                defer_mem[(defer_head + defer_count) % rfles_pkg::DeferDepth] = ev.code[2:0];
                defer_count++;
                res.status = rfles_pkg::STS_DEFERRED;
            end
        end
        else
        begin
            if (user)
            begin
                open_user = ev.code;
                target = resolve_target(user_next[link_state][ev.code[2:0]], ev.disc, ev.dev);
            end
            else
            begin
                target = resolve_target(internal_next[link_state][ev.code - EV_USER_LIMIT],
                                        ev.disc, ev.dev);
            end
            if (target > 4'd7)
            begin
                res.status = rfles_pkg::STS_INVALID_STATE;
            end
            else if (user || target[2:0] != link_state)
            begin
                res.handler = handler_id[link_state][target[2:0]];
                if (res.handler != HND_NONE)
                begin
                    link_busy = 1'b1;
                    res.status = (ev.hres == rfles_pkg::HRES_PENDING) ?
                                 rfles_pkg::STS_PENDING : rfles_pkg::STS_OK;
                end
                link_state = rfles_pkg::link_state_t'(target[2:0]);
            end
            // Completion: replay the oldest deferred event or close the user event
            if (res.status != rfles_pkg::STS_PENDING)
            begin
                link_busy = 1'b0;
                if (defer_count != 0)
                begin
                    res.replay = 1'b1;
                    res.replay_ev = defer_mem[defer_head];
                    defer_head = (defer_head + 1) % rfles_pkg::DeferDepth;
                    defer_count--;
                end
                else if (open_user != rfles_pkg::USER_EV_NONE)
                begin
                    open_user = rfles_pkg::USER_EV_NONE;
                    res.done = 1'b1;
                end
            end
        end
        res.new_state = link_state;
    endtask

    // Favor events that have a table entry in the predicted state
    function automatic logic [3:0] pick_event();
        logic [3:0] code;
        logic       has_entry;
        code = 4'($urandom_range(15));
        if ($urandom_range(99) < 15)
            return code;
        for (int i = 0; i < 16; i++)
        begin
            code = 4'($urandom_range(14));
            if (code < EV_USER_LIMIT)
                has_entry = user_next[link_state][code[2:0]] != rfles_pkg::TGT_NONE;
            else
                has_entry = internal_next[link_state][code - EV_USER_LIMIT]
                            != rfles_pkg::TGT_NONE;
            if (has_entry)
                return code;
        end
        return code;
    endfunction

    // Offer one event, hold it until the transfer, then record its result
    task automatic transfer_event(input link_event_t item, input logic typed,
                                  input seq_result_t typed_want);
        seq_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        event_code        <= item.code;
        disc_mode_check   <= item.disc;
        device_type_check <= item.dev;
        handler_result    <= item.hres;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sequence_event(item, predicted);
        predicted_results.push_back(typed ? typed_want : predicted);
        transfers++;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Drive the result-side stall, with one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        seq_result_t want;
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no event waiting, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("status", want.status, status);
                check_field("new_state", want.new_state, new_state);
                check_field("handler_called", want.handler, handler_called);
                check_field("replay_valid", want.replay, replay_valid);
                check_field("replay_event", want.replay_ev, replay_event);
                check_field("user_done", want.done, user_done);
                results_checked++;
                replays_seen += replay_valid;
                done_seen += user_done;
                full_seen += (status == rfles_pkg::STS_QUEUE_FULL);
                pending_seen += (status == rfles_pkg::STS_PENDING);
            end
        end
    end

    // Watchdog: end the run when transfers stop
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int          idle_by_phase [4];
        int          stall_by_phase [4];
        link_event_t item;
        idle_by_phase  = '{0, 76, 0, 23};
        stall_by_phase = '{0, 0, 76, 23};
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        event_code        <= EV_INIT;
        disc_mode_check   <= 1'b0;
        device_type_check <= 1'b0;
        handler_result    <= HRES_OK;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_pending    = 1'b0;
        hold_left       = 0;
        quiet_cycles    = 0;
        mismatches      = 0;
        transfers       = 0;
        results_checked = 0;
        replays_seen    = 0;
        done_seen       = 0;
        full_seen       = 0;
        pending_seen    = 0;
        link_state  = rfles_pkg::ST_IDLE;
        link_busy   = 1'b0;
        open_user   = rfles_pkg::USER_EV_NONE;
        defer_head  = 0;
        defer_count = 0;

        // Hold reset, then release
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence
        for (int r = 0; r < DIRECTED_LEN; r++)
            transfer_event(directed_plan[r].item, directed_plan[r].typed,
                           directed_plan[r].want);

        // Random sequences under each idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_by_phase[phase];
            recv_stall_pct  = stall_by_phase[phase];
            if (phase == 0)
                hold_pending = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item.code = pick_event();
                item.disc = 1'($urandom_range(1));
                item.dev  = 1'($urandom_range(1));
                item.hres = ($urandom_range(99) < 30) ? rfles_pkg::HRES_PENDING
                                                      : 2'($urandom_range(3));
                transfer_event(item, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d event transfers and %0d checked results under four idling",
                 transfers, results_checked);
        $display("patterns: %0d pending, %0d replays, %0d user completions, %0d queue-full drops",
                 pending_seen, replays_seen, done_seen, full_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
